### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. PADC_ASSERT expects clk_i and rst_ni in scope, PADC_ASSERT_ALWAYS only clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define PADC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define PADC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PADC_ASSERT(name, prop, msg)
`define PADC_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### hw/rtl/padc_pkg.sv
package padc_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int PCT_W            = 14;
  localparam int QUOT_W           = 14;
  localparam int PROD_W           = 30;
  localparam int CNT_W            = 4;
  localparam int APB_ADDR_W       = 5;
  localparam int APB_DATA_W       = 32;

  localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(10000);
  localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(15);

  localparam logic [SAMPLE_W-1:0] CAL_LOW_RST  = 16'h0000;
  localparam logic [SAMPLE_W-1:0] CAL_HIGH_RST = 16'h7fff;
  localparam logic [CNT_W-1:0]    LIMIT_RST    = CNT_W'(5);

  typedef enum logic [2:0] {
    REG_THR_LOW  = 3'd0,
    REG_THR_HIGH = 3'd1,
    REG_RGN_LOW  = 3'd2,
    REG_RGN_HIGH = 3'd3,
    REG_LIMIT    = 3'd4
  } padc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SAVE,
    ST_DONE
  } padc_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] thr_low;
    logic signed [SAMPLE_W-1:0] thr_high;
    logic signed [SAMPLE_W-1:0] rgn_low;
    logic signed [SAMPLE_W-1:0] rgn_high;
    logic        [CNT_W-1:0]    limit;
  } padc_cfg_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic prep;
    logic mul;
    logic div_step;
    logic save;
    logic out_load;
    logic sel_regen;
  } padc_cmd_t;

  typedef struct packed {
    logic stuck;
  } padc_stat_t;

endpackage

### hw/rtl/padc_if.sv
interface padc_samp_if;
  logic                                valid;
  logic                                ready;
  logic signed [padc_pkg::SAMPLE_W-1:0] throttle_sample;
  logic signed [padc_pkg::SAMPLE_W-1:0] regen_sample;

  modport source (output valid, output throttle_sample, output regen_sample, input ready);
  modport sink   (input valid, input throttle_sample, input regen_sample, output ready);
endinterface

interface padc_pct_if;
  logic                         valid;
  logic                         ready;
  logic [padc_pkg::PCT_W-1:0]   throttle_pct;
  logic [padc_pkg::PCT_W-1:0]   regen_pct;
  logic                         throttle_stuck;

  modport source (output valid, output throttle_pct, output regen_pct,
                  output throttle_stuck, input ready);
  modport sink   (input valid, input throttle_pct, input regen_pct,
                  input throttle_stuck, output ready);
endinterface

### hw/rtl/pedal_adc_percent_conditioner.sv
// Channel | Dir | Payload                                        | Handshake
// samp_i  | in  | throttle_sample[16], regen_sample[16]          | valid / ready
// pct_o   | out | throttle_pct[14], regen_pct[14], throttle_stuck | valid / ready
// APB     | in  | 5 registers at byte address 4*i, 32-bit data   | psel / penable
//
// One transaction at a time: when the sample is mapped, the result takes two passes
// of the shared 14-step restoring divider, and a new transaction is accepted only
// once the result has been loaded into the output register; the divider is skipped
// when the stuck detector trips. A new transaction is taken while the
// previous result still waits in the output register; a stalled output holds
// the block in its final state. Reset clears the calibration to its defaults.
`include "assert_macros.svh"

module pedal_adc_percent_conditioner #(
  parameter int SAMPLE_BITS = padc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  padc_samp_if.sink                         samp_i,
  padc_pct_if.source                        pct_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [padc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [padc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [padc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  padc_pkg::padc_cfg_t  cfg;
  padc_pkg::padc_cmd_t  cmd;
  padc_pkg::padc_stat_t stat;
  logic                 in_ready, out_valid;

  padc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  padc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (samp_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pct_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  padc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .throttle_sample_i (samp_i.throttle_sample),
    .regen_sample_i    (samp_i.regen_sample),
    .throttle_pct_o    (pct_o.throttle_pct),
    .regen_pct_o       (pct_o.regen_pct),
    .throttle_stuck_o  (pct_o.throttle_stuck)
  );

  assign samp_i.ready = in_ready;
  assign pct_o.valid  = out_valid;

  logic in_acc;
  logic pct_ok;
  logic out_stuck;
  logic thr_zero;

  assign in_acc    = samp_i.valid & in_ready;
  assign pct_ok    = (pct_o.throttle_pct <= padc_pkg::FULL_SCALE)
                     && (pct_o.regen_pct <= padc_pkg::FULL_SCALE);
  assign out_stuck = out_valid && pct_o.throttle_stuck;
  assign thr_zero  = (pct_o.throttle_pct == '0);

  `PADC_ASSERT(a_one_at_a_time, in_acc |=> !in_ready, "input taken while busy")
  `PADC_ASSERT(a_pct_range, out_valid |-> pct_ok, "percent above full scale")
  `PADC_ASSERT(a_stuck_zero, out_stuck |-> thr_zero, "stuck result with nonzero throttle")
  `PADC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid, "result valid during reset")

endmodule

### hw/rtl/padc_cfg_regs.sv
module padc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [padc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [padc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [padc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output padc_pkg::padc_cfg_t                 cfg_o
);

  padc_pkg::padc_cfg_t cfg_q;
  padc_pkg::padc_reg_e idx;
  logic                wr_en;

  assign idx    = padc_pkg::padc_reg_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_low  <= padc_pkg::CAL_LOW_RST;
      cfg_q.thr_high <= padc_pkg::CAL_HIGH_RST;
      cfg_q.rgn_low  <= padc_pkg::CAL_LOW_RST;
      cfg_q.rgn_high <= padc_pkg::CAL_HIGH_RST;
      cfg_q.limit    <= padc_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        padc_pkg::REG_THR_LOW:  cfg_q.thr_low  <= pwdata[15:0];
        padc_pkg::REG_THR_HIGH: cfg_q.thr_high <= pwdata[15:0];
        padc_pkg::REG_RGN_LOW:  cfg_q.rgn_low  <= pwdata[15:0];
        padc_pkg::REG_RGN_HIGH: cfg_q.rgn_high <= pwdata[15:0];
        padc_pkg::REG_LIMIT:    cfg_q.limit    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      padc_pkg::REG_THR_LOW:  prdata = {16'h0000, cfg_q.thr_low};
      padc_pkg::REG_THR_HIGH: prdata = {16'h0000, cfg_q.thr_high};
      padc_pkg::REG_RGN_LOW:  prdata = {16'h0000, cfg_q.rgn_low};
      padc_pkg::REG_RGN_HIGH: prdata = {16'h0000, cfg_q.rgn_high};
      padc_pkg::REG_LIMIT:    prdata = {28'h0000000, cfg_q.limit};
      default:                prdata = '0;
    endcase
  end

endmodule

### hw/rtl/padc_datapath.sv
module padc_datapath #(
  parameter int SAMPLE_BITS = padc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  padc_pkg::padc_cfg_t                 cfg_i,
  input  padc_pkg::padc_cmd_t                 cmd_i,
  output padc_pkg::padc_stat_t                stat_o,
  input  logic [padc_pkg::SAMPLE_W-1:0]       throttle_sample_i,
  input  logic [padc_pkg::SAMPLE_W-1:0]       regen_sample_i,
  output logic [padc_pkg::PCT_W-1:0]          throttle_pct_o,
  output logic [padc_pkg::PCT_W-1:0]          regen_pct_o,
  output logic                                throttle_stuck_o
);

  localparam int SW  = padc_pkg::SAMPLE_W;
  localparam int PW  = padc_pkg::PCT_W;
  localparam int QW  = padc_pkg::QUOT_W;
  localparam int PRW = padc_pkg::PROD_W;
  localparam int CW  = padc_pkg::CNT_W;
  localparam int EXT = SW - SAMPLE_BITS;

  // Sign extension from the sample width: shift up, then shift back arithmetically.
  logic [SW-1:0]        thr_sh, rgn_sh;
  logic signed [SW-1:0] thr_ext, rgn_ext;

  assign thr_sh  = throttle_sample_i << EXT;
  assign rgn_sh  = regen_sample_i << EXT;
  assign thr_ext = $signed(thr_sh) >>> EXT;
  assign rgn_ext = $signed(rgn_sh) >>> EXT;

  logic signed [SW-1:0] thr_s_q, rgn_s_q;
  logic signed [SW-1:0] last_q;
  logic [CW-1:0]        cnt_q;
  logic                 stuck_q;
  logic [PW-1:0]        held_q;
  logic [PW-1:0]        thr_pct_q;

  // Stuck detector.
  logic signed [SW:0] arm, thr17;
  logic               match;
  logic [CW-1:0]      cnt_inc;
  logic               stuck;

  assign arm     = ($signed({cfg_i.thr_high[SW-1], cfg_i.thr_high})
                    + $signed({{SW{1'b0}}, cfg_i.thr_high[SW-1]})) >>> 1;
  assign thr17   = $signed({thr_s_q[SW-1], thr_s_q});
  assign match   = (thr_s_q == last_q) && (thr17 > arm);
  assign cnt_inc = (cnt_q == padc_pkg::COUNT_MAX) ? cnt_q : cnt_q + CW'(1);
  assign stuck   = match && (cnt_inc >= cfg_i.limit);
  assign stat_o.stuck = stuck;

  // Operand preparation for the shared mapper.
  logic signed [SW-1:0] op_s, op_lo, op_hi;
  logic signed [SW:0]   num17, den17;
  logic                 op_zero, op_sat;

  assign op_s    = cmd_i.sel_regen ? rgn_s_q : thr_s_q;
  assign op_lo   = cmd_i.sel_regen ? cfg_i.rgn_low : cfg_i.thr_low;
  assign op_hi   = cmd_i.sel_regen ? cfg_i.rgn_high : cfg_i.thr_high;
  assign num17   = $signed({op_s[SW-1], op_s}) - $signed({op_lo[SW-1], op_lo});
  assign den17   = $signed({op_hi[SW-1], op_hi}) - $signed({op_lo[SW-1], op_lo});
  assign op_zero = num17[SW] | (num17 == '0) | den17[SW] | (den17 == '0);
  assign op_sat  = (num17 >= den17);

  logic [SW-1:0] num_q, den_q;
  logic          zero_q, sat_q;

  // Restoring divider: the quotient is below full scale whenever num < den,
  // so the top bits of the product already sit below the divisor.
  logic [PRW-1:0] prod;
  logic [SW-1:0]  rem_q;
  logic [QW-1:0]  lo_q, quot_q;
  logic [SW:0]    trial, diff;
  logic           qbit;

  assign prod  = PRW'(num_q) * PRW'(padc_pkg::FULL_SCALE);
  assign trial = {rem_q, lo_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  logic [PW-1:0] map_res;
  assign map_res = zero_q ? '0 : (sat_q ? padc_pkg::FULL_SCALE : PW'(quot_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      stuck_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        cnt_q   <= match ? cnt_inc : '0;
        stuck_q <= stuck;
        if (!stuck) begin
          last_q <= thr_s_q;
        end
      end
      if (cmd_i.save && cmd_i.sel_regen) begin
        held_q <= map_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      thr_s_q <= thr_ext;
      rgn_s_q <= rgn_ext;
    end
    if (cmd_i.prep) begin
      num_q  <= num17[SW-1:0];
      den_q  <= den17[SW-1:0];
      zero_q <= op_zero;
      sat_q  <= op_sat;
    end
    if (cmd_i.mul) begin
      rem_q <= prod[PRW-1:QW];
      lo_q  <= prod[QW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= qbit ? diff[SW-1:0] : trial[SW-1:0];
      lo_q   <= {lo_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], qbit};
    end
    if (cmd_i.save && !cmd_i.sel_regen) begin
      thr_pct_q <= map_res;
    end
    if (cmd_i.out_load) begin
      throttle_pct_o   <= stuck_q ? '0 : thr_pct_q;
      regen_pct_o      <= held_q;
      throttle_stuck_o <= stuck_q;
    end
  end

endmodule

### hw/rtl/padc_ctrl.sv
module padc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  padc_pkg::padc_stat_t  stat_i,
  output padc_pkg::padc_cmd_t   cmd_o
);

  localparam int STEP_W = $clog2(padc_pkg::QUOT_W);

  padc_pkg::padc_state_e state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  sel_q, sel_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= padc_pkg::ST_IDLE;
      step_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.sel_regen = sel_q;

    unique case (state_q)
      padc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = padc_pkg::ST_EVAL;
        end
      end
      padc_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        sel_d      = 1'b0;
        state_d    = stat_i.stuck ? padc_pkg::ST_DONE : padc_pkg::ST_PREP;
      end
      padc_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = padc_pkg::ST_MUL;
      end
      padc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = '0;
        state_d   = padc_pkg::ST_DIV;
      end
      padc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(padc_pkg::QUOT_W - 1)) begin
          state_d = padc_pkg::ST_SAVE;
        end
      end
      padc_pkg::ST_SAVE: begin
        cmd_o.save = 1'b1;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = padc_pkg::ST_PREP;
        end else begin
          state_d = padc_pkg::ST_DONE;
        end
      end
      padc_pkg::ST_DONE: begin
        // The result register is free once its last transaction completes.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = padc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = padc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
